[hw/rtl/smm_pkg.sv]
// smm_pkg: shared types and constants of the square matrix multiplier
// no dependencies; used by smm_mac, smm_ctrl, the top and the checker by scoped names
`default_nettype none

package smm_pkg;

  // build defaults
  localparam int unsigned MAX_DIM_DEFAULT    = 8;
  localparam int unsigned ELEM_WIDTH_DEFAULT = 32;

  // port field widths
  localparam int unsigned IDX_FIELD_W = 3;
  localparam int unsigned VAL_FIELD_W = 32;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned IN_DATA_W   = 40;  // row, col, value, padded to bytes
  localparam int unsigned OUT_DATA_W  = 40;  // out_row, out_col, product, padded
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned SIZE_W      = 4;

  // input operation codes (carried in tuser)
  localparam logic [OP_W-1:0] OP_LOAD_FIRST  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_SECOND = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE     = 2'd2;

  // register map: word index taken from paddr[2]
  localparam logic REG_SIZE_IN_USE = 1'b0;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

  // issue flags from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic vld;    // a pair of operands is being read
    logic first;  // first term of a dot product
    logic last;   // final term of a dot product
  } mac_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/smm_ram.sv]
// smm_ram: generic single write port, single read port RAM with registered read
// no dependencies
`default_nettype none

module smm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[hw/rtl/smm_mac.sv]
// smm_mac: shared multiply-accumulate unit, operands from the two element RAMs
// depends on smm_pkg (mac_ctl_t)
`default_nettype none

module smm_mac #(
  parameter int unsigned ELEM_WIDTH = smm_pkg::ELEM_WIDTH_DEFAULT
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire smm_pkg::mac_ctl_t     issue_i,  // flags at read address time
  input  wire logic [ELEM_WIDTH-1:0] a_i,      // RAM data, the cycle after issue
  input  wire logic [ELEM_WIDTH-1:0] b_i,
  output logic      [ELEM_WIDTH-1:0] acc_o,
  output logic                       done_o    // acc_o holds a finished sum
);

  smm_pkg::mac_ctl_t rd_q, mul_q;
  logic [ELEM_WIDTH-1:0]   prod_q, acc_q, acc_d;
  logic [2*ELEM_WIDTH-1:0] prod_full;
  logic                    done_q;

  // flags follow the RAM read latency, then the multiplier register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q   <= '0;
      mul_q  <= '0;
      done_q <= 1'b0;
    end else begin
      rd_q   <= issue_i;
      mul_q  <= rd_q;
      done_q <= mul_q.vld && mul_q.last;
    end
  end

  // multiplier stage, only the low bits matter under wrapping
  assign prod_full = a_i * b_i;

  always_ff @(posedge clk_i) begin
    if (rd_q.vld) begin
      prod_q <= prod_full[ELEM_WIDTH-1:0];
    end
  end

  // accumulate, restarting on the first term
  always_comb begin
    acc_d = acc_q;
    if (mul_q.vld) begin
      acc_d = (mul_q.first ? '0 : acc_q) + prod_q;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

[hw/rtl/smm_ctrl.sv]
// smm_ctrl: sequencer walking i, j, k over the product and handing results out
// depends on smm_pkg (mac_ctl_t)
`default_nettype none

module smm_ctrl #(
  parameter int unsigned MAX_DIM = smm_pkg::MAX_DIM_DEFAULT,
  localparam int unsigned IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,     // compute item accepted
  input  wire logic [IDX_W-1:0]  nm1_i,       // dimension minus one
  input  wire logic              acc_done_i,
  input  wire logic              out_free_i,  // output register can take a result
  output logic                   idle_o,
  output smm_pkg::mac_ctl_t      issue_o,
  output logic      [ADDR_W-1:0] a_addr_o,
  output logic      [ADDR_W-1:0] b_addr_o,
  output logic                   emit_o,
  output logic      [IDX_W-1:0]  row_o,
  output logic      [IDX_W-1:0]  col_o,
  output logic                   last_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic             k_last, j_last, i_last;

  assign k_last = (k_q == nm1_i);
  assign j_last = (j_q == nm1_i);
  assign i_last = (i_q == nm1_i);

  // operand addresses: first[i][k] and second[k][j]
  assign a_addr_o = ADDR_W'(i_q) * ADDR_W'(MAX_DIM) + ADDR_W'(k_q);
  assign b_addr_o = ADDR_W'(k_q) * ADDR_W'(MAX_DIM) + ADDR_W'(j_q);

  // next state and counters
  always_comb begin
    state_d       = state_q;
    i_d           = i_q;
    j_d           = j_q;
    k_d           = k_q;
    issue_o       = '0;
    emit_o        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        issue_o.vld   = 1'b1;
        issue_o.first = (k_q == '0);
        issue_o.last  = k_last;
        if (k_last) begin
          k_d     = '0;
          state_d = ST_DRAIN;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (acc_done_i) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free_i) begin
          emit_o = 1'b1;
          if (j_last) begin
            j_d = '0;
            if (i_last) begin
              i_d     = '0;
              state_d = ST_IDLE;
            end else begin
              i_d     = i_q + 1'b1;
              state_d = ST_ISSUE;
            end
          end else begin
            j_d     = j_q + 1'b1;
            state_d = ST_ISSUE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  assign idle_o = (state_q == ST_IDLE);
  assign row_o  = i_q;
  assign col_o  = j_q;
  assign last_o = i_last && j_last;

endmodule

`default_nettype wire

[hw/rtl/square_matrix_multiply.sv]
// square_matrix_multiply: top level, register port, element RAMs, output register
// depends on smm_pkg, smm_ram, smm_mac and smm_ctrl
//
// Input stream: tuser carries the operation. A load of the first or second
// matrix writes one element at (row, col); loads with
// row or col at or beyond MAX_DIM are dropped, op code 3 is dropped.
// A compute item walks the n by n product in row-major order, one result
// transfer per element, tlast on the final one. n comes from the size
// register (0 reads as 1, above MAX_DIM reads as MAX_DIM).
// Each product element needs n operand reads through the single read
// port of each element RAM into the one shared multiplier, then passes
// the RAM, multiplier and accumulator registers and a hand-off state.
// The input is not ready while a compute item runs.
// A stalled receiver holds the result in the output register and freezes
// the sequencer before the next hand-off; nothing is lost.
// Reset clears the sequencer and output valid and sets the size to 8;
// element RAMs are not cleared and must be loaded before use.
`default_nettype none

module square_matrix_multiply #(
  parameter int unsigned MAX_DIM    = smm_pkg::MAX_DIM_DEFAULT,
  parameter int unsigned ELEM_WIDTH = smm_pkg::ELEM_WIDTH_DEFAULT
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // input stream
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // tdata: row [2:0], col [5:3], element_value [37:6], zero [39:38]
  input  wire logic [smm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // tuser: op [1:0]
  input  wire logic [smm_pkg::OP_W-1:0]         s_axis_tuser,
  // result stream
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // tdata: out_row [2:0], out_col [5:3], product_value [37:6], zero [39:38]
  output logic      [smm_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                                  m_axis_tlast,
  // register port
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [smm_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [smm_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [smm_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                  pready
);

  localparam int unsigned IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FW     = smm_pkg::IDX_FIELD_W;
  localparam int unsigned VW     = smm_pkg::VAL_FIELD_W;
  localparam int unsigned SW     = smm_pkg::SIZE_W;

  // size register
  logic [SW-1:0]    size_q;
  logic [SW-1:0]    size_sat;
  logic [IDX_W-1:0] nm1;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == smm_pkg::REG_SIZE_IN_USE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= smm_pkg::SIZE_RESET;
    end else if (cfg_wr) begin
      size_q <= pwdata[SW-1:0];
    end
  end

  assign prdata = (paddr[2] == smm_pkg::REG_SIZE_IN_USE) ? 32'(size_q) : '0;

  // dimension in use, saturated to 1..MAX_DIM
  always_comb begin
    if (size_q == '0) begin
      size_sat = SW'(1);
    end else if (size_q > SW'(MAX_DIM)) begin
      size_sat = SW'(MAX_DIM);
    end else begin
      size_sat = size_q;
    end
  end

  assign nm1 = IDX_W'(size_sat - SW'(1));

  // input field unpacking
  logic [FW-1:0]          in_row, in_col;
  logic [VW-1:0]          in_val;
  logic                   in_xfer, in_range;
  logic                   we_first, we_second, start;
  logic [ADDR_W-1:0]      waddr;
  logic [ELEM_WIDTH-1:0]  wdata;

  assign in_row   = s_axis_tdata[FW-1:0];
  assign in_col   = s_axis_tdata[2*FW-1:FW];
  assign in_val   = s_axis_tdata[2*FW+VW-1:2*FW];
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign in_range = ({1'b0, in_row} < (FW+1)'(MAX_DIM)) &&
                    ({1'b0, in_col} < (FW+1)'(MAX_DIM));

  // decode of the operation
  always_comb begin
    we_first  = 1'b0;
    we_second = 1'b0;
    start     = 1'b0;
    unique case (s_axis_tuser)
      smm_pkg::OP_LOAD_FIRST:  we_first  = in_xfer && in_range;
      smm_pkg::OP_LOAD_SECOND: we_second = in_xfer && in_range;
      smm_pkg::OP_COMPUTE:     start     = in_xfer;
      default: ;
    endcase
  end

  assign waddr = ADDR_W'(in_row) * ADDR_W'(MAX_DIM) + ADDR_W'(in_col);
  assign wdata = in_val[ELEM_WIDTH-1:0];

  // element stores and datapath
  smm_pkg::mac_ctl_t      issue;
  logic [ADDR_W-1:0]      a_addr, b_addr;
  logic [ELEM_WIDTH-1:0]  a_data, b_data, acc;
  logic                   acc_done, emit, idle, out_free, res_last;
  logic [IDX_W-1:0]       res_row, res_col;

  smm_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_first_ram (
    .clk_i   (clk_i),
    .we_i    (we_first),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (a_addr),
    .rdata_o (a_data)
  );

  smm_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_second_ram (
    .clk_i   (clk_i),
    .we_i    (we_second),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (b_addr),
    .rdata_o (b_data)
  );

  smm_mac #(.ELEM_WIDTH(ELEM_WIDTH)) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (issue),
    .a_i     (a_data),
    .b_i     (b_data),
    .acc_o   (acc),
    .done_o  (acc_done)
  );

  smm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .nm1_i      (nm1),
    .acc_done_i (acc_done),
    .out_free_i (out_free),
    .idle_o     (idle),
    .issue_o    (issue),
    .a_addr_o   (a_addr),
    .b_addr_o   (b_addr),
    .emit_o     (emit),
    .row_o      (res_row),
    .col_o      (res_col),
    .last_o     (res_last)
  );

  assign s_axis_tready = idle;

  // output register
  logic                         out_vld_q;
  logic [smm_pkg::OUT_DATA_W-1:0] out_data_q;
  logic                         out_last_q;
  logic signed [ELEM_WIDTH-1:0] acc_s;
  logic [VW-1:0]                prod_ext;

  assign out_free = !out_vld_q || m_axis_tready;
  assign acc_s    = acc;
  assign prod_ext = VW'(acc_s);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= {2'b00, prod_ext, FW'(res_col), FW'(res_row)};
      out_last_q <= res_last;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

[hw/rtl/smm_checker.sv]
// smm_checker: port-level checks of square_matrix_multiply, bound to the top
// depends on smm_pkg and square_matrix_multiply
`default_nettype none

module smm_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             s_axis_tvalid,
  input wire logic                             s_axis_tready,
  input wire logic [smm_pkg::OP_W-1:0]         s_axis_tuser,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  input wire logic [smm_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input wire logic                             m_axis_tlast,
  input wire logic                             psel,
  input wire logic                             penable,
  input wire logic                             pwrite,
  input wire logic [smm_pkg::APB_ADDR_W-1:0]   paddr,
  input wire logic [smm_pkg::APB_DATA_W-1:0]   pwdata,
  input wire logic [smm_pkg::APB_DATA_W-1:0]   prdata
);

  // a stalled result keeps its contents
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // a compute transfer makes the input busy
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == smm_pkg::OP_COMPUTE) |=>
      !s_axis_tready)
    else $error("input still ready after compute transfer");

  // results are produced only by a running product, never while idle
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared while idle");

  // size register reads back what was written
  a_size_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && (paddr[2] == smm_pkg::REG_SIZE_IN_USE)) ##1
      (paddr[2] == smm_pkg::REG_SIZE_IN_USE) |->
      prdata[smm_pkg::SIZE_W-1:0] == $past(pwdata[smm_pkg::SIZE_W-1:0]))
    else $error("size register readback mismatch");

endmodule

bind square_matrix_multiply smm_checker u_smm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata)
);

`default_nettype wire
